// ===== hw/rtl/wcsu_pkg.sv =====
// wcsu_pkg: shared widths, codes, sequencer states and memory control struct
// for the wolff cluster spin update core. No dependencies.
package wcsu_pkg;

	// lattice side used when the top level is not overridden
	localparam int SIDE_DEFAULT = 256;

	// field widths of the item and result channels
	localparam int CMD_W    = 2;
	localparam int COORD_W  = 8;
	localparam int RAND_W   = 16;
	localparam int THR_W    = 17;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 17;
	localparam int MAG_W    = 18;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam int REG_BOND_THRESHOLD = 0;

	// neighbours tested per grow step
	localparam int NBR_COUNT = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_SPIN  = 2'd0,
		CMD_START       = 2'd1,
		CMD_GROW        = 2'd2,
		CMD_READ_STATUS = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ACCEPTED    = 2'd0,
		STAT_FINISHED    = 2'd1,
		STAT_REJECTED    = 2'd2,
		STAT_IDLE_REPORT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SPIN_RD,
		S_SPIN_EXEC,
		S_HEAD_RD,
		S_HEAD_LATCH,
		S_NBR,
		S_GROW_CHK,
		S_FLIP,
		S_RESULT
	} seq_state_t;

	// strobes from the sequencer to the lattice stores
	typedef struct packed {
		logic site_re;
		logic queue_re;
		logic spin_we;
		logic spin_wbit;
		logic mark_we;
		logic mark_wbit;
		logic queue_we;
	} mem_ctl_t;

endpackage

// ===== hw/rtl/wcsu_stream_if.sv =====
// wcsu_item_if and wcsu_result_if: valid/ready channels of the core, each
// carrying its payload fields. Depends on wcsu_pkg.
interface wcsu_item_if;
	import wcsu_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] col;
	logic               spin_up;
	logic [RAND_W-1:0]  rand_row_next;
	logic [RAND_W-1:0]  rand_row_prev;
	logic [RAND_W-1:0]  rand_col_next;
	logic [RAND_W-1:0]  rand_col_prev;

	modport source (
		output valid, cmd, row, col, spin_up,
		output rand_row_next, rand_row_prev, rand_col_next, rand_col_prev,
		input  ready
	);
	modport sink (
		input  valid, cmd, row, col, spin_up,
		input  rand_row_next, rand_row_prev, rand_col_next, rand_col_prev,
		output ready
	);
endinterface

interface wcsu_result_if;
	import wcsu_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [COUNT_W-1:0]      cluster_size;
	logic [COUNT_W-1:0]      pending_sites;
	logic signed [MAG_W-1:0] magnetization;

	modport source (
		output valid, status, cluster_size, pending_sites, magnetization,
		input  ready
	);
	modport sink (
		input  valid, status, cluster_size, pending_sites, magnetization,
		output ready
	);
endinterface

// ===== hw/rtl/wolff_cluster_spin_update_core.sv =====
// Wolff cluster update engine for a SIDE x SIDE Ising lattice with periodic
// edges: items write spins, seed a cluster, grow it one queued site per item
// with four supplied random fractions, or read status; each item gives one
// result. Items are handled one at a time and the item port is ready only
// between items. A spin write reads the spin store, then writes it if the
// spin changes; a cluster start reads the spin store, then writes the mark
// store and the fifo. A grow step does one fifo read, then four neighbour
// tests through the one bond comparator overlapped with the store reads;
// the grow step that empties the fifo then flips the cluster, as the flip
// walks the queue one site per cycle. After reset the spin and mark stores
// are cleared one entry per cycle, all 2**(2*ceil(log2 SIDE)) entries
// (65536 at SIDE 256), while items wait; register writes are taken throughout.
module wolff_cluster_spin_update_core #(
	parameter int SIDE = wcsu_pkg::SIDE_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	wcsu_item_if.sink                   items,
	wcsu_result_if.source               results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wcsu_pkg::CFG_AW-1:0] paddr,
	input  logic [wcsu_pkg::CFG_DW-1:0] pwdata,
	output logic [wcsu_pkg::CFG_DW-1:0] prdata,
	output logic                        pready
);
	import wcsu_pkg::*;

	localparam int RW    = $clog2(SIDE);
	localparam int AW    = 2 * RW;
	localparam int SITES = SIDE * SIDE;
	localparam int QW    = $clog2(SITES);

	logic [THR_W-1:0] bond_threshold;
	mem_ctl_t         mem_ctl;
	logic [AW-1:0]    site_raddr, site_waddr, queue_wdata, queue_rdata;
	logic [QW-1:0]    queue_raddr, queue_waddr;
	logic             spin_rdata, mark_rdata;

	// configuration register
	wcsu_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.bond_threshold (bond_threshold)
	);

	// sequencer and counters
	wcsu_ctrl #(.SIDE(SIDE)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.items          (items),
		.results        (results),
		.bond_threshold (bond_threshold),
		.mem_ctl        (mem_ctl),
		.site_raddr     (site_raddr),
		.site_waddr     (site_waddr),
		.queue_raddr    (queue_raddr),
		.queue_waddr    (queue_waddr),
		.queue_wdata    (queue_wdata),
		.spin_rdata     (spin_rdata),
		.mark_rdata     (mark_rdata),
		.queue_rdata    (queue_rdata)
	);

	// lattice and fifo memories
	wcsu_store #(.AW(AW), .QD(SITES), .QW(QW)) u_store (
		.clk         (clk),
		.ctl         (mem_ctl),
		.site_raddr  (site_raddr),
		.site_waddr  (site_waddr),
		.queue_raddr (queue_raddr),
		.queue_waddr (queue_waddr),
		.queue_wdata (queue_wdata),
		.spin_rdata  (spin_rdata),
		.mark_rdata  (mark_rdata),
		.queue_rdata (queue_rdata)
	);

endmodule

// ===== hw/rtl/wcsu_cfg.sv =====
// wcsu_cfg: apb-style register holding the bond threshold.
// Depends on wcsu_pkg.
module wcsu_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [wcsu_pkg::CFG_AW-1:0] paddr,
	input  logic [wcsu_pkg::CFG_DW-1:0] pwdata,
	output logic [wcsu_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	output logic [wcsu_pkg::THR_W-1:0]  bond_threshold
);
	import wcsu_pkg::*;

	logic                 hit;
	logic [THR_W-1:0]     thr_q;

	// register index is the word address
	assign hit    = (paddr[CFG_AW-1:2] == 1'(REG_BOND_THRESHOLD));
	assign pready = 1'b1;

	// write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && hit) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = CFG_DW'(thr_q);
		end
	end

	assign bond_threshold = thr_q;

endmodule

// ===== hw/rtl/wcsu_store.sv =====
// wcsu_store: spin, mark and cluster-site memories, one write and one
// registered read port each. Depends on wcsu_pkg.
module wcsu_store #(
	parameter int AW = 16,
	parameter int QD = 65536,
	parameter int QW = 16
) (
	input  logic               clk,
	input  wcsu_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]      site_raddr,
	input  logic [AW-1:0]      site_waddr,
	input  logic [QW-1:0]      queue_raddr,
	input  logic [QW-1:0]      queue_waddr,
	input  logic [AW-1:0]      queue_wdata,
	output logic               spin_rdata,
	output logic               mark_rdata,
	output logic [AW-1:0]      queue_rdata
);
	import wcsu_pkg::*;

	logic          spin_mem  [2**AW];
	logic          mark_mem  [2**AW];
	logic [AW-1:0] queue_mem [QD];

	// spin lattice
	always_ff @(posedge clk) begin
		if (ctl.spin_we) begin
			spin_mem[site_waddr] <= ctl.spin_wbit;
		end
		if (ctl.site_re) begin
			spin_rdata <= spin_mem[site_raddr];
		end
	end

	// cluster marks, read alongside the spin
	always_ff @(posedge clk) begin
		if (ctl.mark_we) begin
			mark_mem[site_waddr] <= ctl.mark_wbit;
		end
		if (ctl.site_re) begin
			mark_rdata <= mark_mem[site_raddr];
		end
	end

	// cluster site fifo storage
	always_ff @(posedge clk) begin
		if (ctl.queue_we) begin
			queue_mem[queue_waddr] <= queue_wdata;
		end
		if (ctl.queue_re) begin
			queue_rdata <= queue_mem[queue_raddr];
		end
	end

endmodule

// ===== hw/rtl/wcsu_ctrl.sv =====
// wcsu_ctrl: command sequencer with the shared bond test, fifo pointers,
// magnetization counter and result register. Depends on wcsu_pkg and the
// channel interfaces.
module wcsu_ctrl #(
	parameter int SIDE = wcsu_pkg::SIDE_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	wcsu_item_if.sink                 items,
	wcsu_result_if.source             results,
	input  logic [wcsu_pkg::THR_W-1:0] bond_threshold,
	output wcsu_pkg::mem_ctl_t        mem_ctl,
	output logic [2*$clog2(SIDE)-1:0] site_raddr,
	output logic [2*$clog2(SIDE)-1:0] site_waddr,
	output logic [$clog2(SIDE*SIDE)-1:0] queue_raddr,
	output logic [$clog2(SIDE*SIDE)-1:0] queue_waddr,
	output logic [2*$clog2(SIDE)-1:0] queue_wdata,
	input  logic                      spin_rdata,
	input  logic                      mark_rdata,
	input  logic [2*$clog2(SIDE)-1:0] queue_rdata
);
	import wcsu_pkg::*;

	localparam int RW     = $clog2(SIDE);
	localparam int AW     = 2 * RW;
	localparam int SITES  = SIDE * SIDE;
	localparam int QW     = $clog2(SITES);
	localparam int CW     = $clog2(SITES + 1);
	localparam int MW     = CW + 1;
	localparam int KW     = $clog2(NBR_COUNT + 1);
	localparam int WRAP_W = $clog2(SIDE + 1) + COORD_W;
	localparam logic signed [MW-1:0] MAG_INIT = MW'(-SITES);
	localparam logic signed [MW-1:0] SPIN_STEP = MW'(2);

	seq_state_t state_q, state_d;

	cmd_t                   cmd_q;
	logic [RW-1:0]          row_q, col_q;
	logic                   up_q;
	logic [RAND_W-1:0]      rand_q [NBR_COUNT];
	status_t                status_q;
	logic [CW-1:0]          head_q, tail_q, walk_q;
	logic                   building_q, cluster_spin_q;
	logic signed [MW-1:0]   total_q;
	logic [AW-1:0]          clr_q;
	logic [KW-1:0]          k_q;
	logic [RW-1:0]          cur_row_q, cur_col_q;
	logic                   nbr_v_s1, flip_v_s1;
	logic [AW-1:0]          nbr_addr_s1;
	logic [RAND_W-1:0]      nbr_rand_s1;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [COUNT_W-1:0]     out_size_q, out_pending_q;
	logic signed [MAG_W-1:0] out_mag_q;

	logic [AW-1:0] site;
	logic [AW-1:0] nbr_addr;
	logic          nbr_issue, nbr_join, walk_issue, slot_free, grow_ok;

	// reduce an input coordinate modulo the side, one conditional subtract per bit
	function automatic logic [RW-1:0] wrap_coord(input logic [COORD_W-1:0] v);
		logic [WRAP_W-1:0] acc;
		acc = WRAP_W'(v);
		for (int k = COORD_W - 1; k >= 0; k--) begin
			if (acc >= (WRAP_W'(SIDE) << k)) begin
				acc = acc - (WRAP_W'(SIDE) << k);
			end
		end
		return RW'(acc);
	endfunction

	function automatic logic [RW-1:0] inc_wrap(input logic [RW-1:0] v);
		return (v == RW'(SIDE - 1)) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [RW-1:0] dec_wrap(input logic [RW-1:0] v);
		return (v == '0) ? RW'(SIDE - 1) : v - 1'b1;
	endfunction

	assign site        = {row_q, col_q};
	assign items.ready = (state_q == S_IDLE);
	assign slot_free   = !out_valid_q || results.ready;
	assign grow_ok     = building_q && (head_q < tail_q);
	assign nbr_issue   = (state_q == S_NBR) && (k_q < KW'(NBR_COUNT));
	assign walk_issue  = (state_q == S_FLIP) && (walk_q < tail_q);

	// neighbour address in test order: row+1, row-1, col+1, col-1
	always_comb begin
		unique case (k_q[1:0])
			2'd0:    nbr_addr = {inc_wrap(cur_row_q), cur_col_q};
			2'd1:    nbr_addr = {dec_wrap(cur_row_q), cur_col_q};
			2'd2:    nbr_addr = {cur_row_q, inc_wrap(cur_col_q)};
			default: nbr_addr = {cur_row_q, dec_wrap(cur_col_q)};
		endcase
	end

	// shared bond test on the neighbour read back this cycle
	assign nbr_join = (state_q == S_NBR) && nbr_v_s1 && (spin_rdata == cluster_spin_q) &&
		!mark_rdata && ({1'b0, nbr_rand_s1} < bond_threshold) && (tail_q < CW'(SITES));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == {AW{1'b1}}) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (items.valid) begin
					unique case (cmd_t'(items.cmd))
						CMD_WRITE_SPIN, CMD_START: state_d = building_q ? S_RESULT : S_SPIN_RD;
						CMD_GROW:                  state_d = grow_ok ? S_HEAD_RD : S_RESULT;
						default:                   state_d = S_RESULT;
					endcase
				end
			end
			S_SPIN_RD:    state_d = S_SPIN_EXEC;
			S_SPIN_EXEC:  state_d = S_RESULT;
			S_HEAD_RD:    state_d = S_HEAD_LATCH;
			S_HEAD_LATCH: state_d = S_NBR;
			S_NBR: begin
				if (k_q == KW'(NBR_COUNT)) state_d = S_GROW_CHK;
			end
			S_GROW_CHK:   state_d = (head_q >= tail_q) ? S_FLIP : S_RESULT;
			S_FLIP: begin
				if (!walk_issue && !flip_v_s1) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) state_d = S_IDLE;
			end
			default:      state_d = S_CLEAR;
		endcase
	end

	// memory strobes and addresses
	always_comb begin
		mem_ctl     = '0;
		site_raddr  = site;
		site_waddr  = site;
		queue_raddr = head_q[QW-1:0];
		queue_waddr = tail_q[QW-1:0];
		queue_wdata = site;
		unique case (state_q)
			S_CLEAR: begin
				mem_ctl.spin_we = 1'b1;
				mem_ctl.mark_we = 1'b1;
				site_waddr      = clr_q;
			end
			S_SPIN_RD: begin
				mem_ctl.site_re = 1'b1;
			end
			S_SPIN_EXEC: begin
				if (cmd_q == CMD_WRITE_SPIN) begin
					mem_ctl.spin_we   = (spin_rdata != up_q);
					mem_ctl.spin_wbit = up_q;
				end else begin
					mem_ctl.mark_we   = 1'b1;
					mem_ctl.mark_wbit = 1'b1;
					mem_ctl.queue_we  = 1'b1;
					queue_waddr       = '0;
				end
			end
			S_HEAD_RD: begin
				mem_ctl.queue_re = 1'b1;
			end
			S_NBR: begin
				mem_ctl.site_re   = nbr_issue;
				site_raddr        = nbr_addr;
				mem_ctl.mark_we   = nbr_join;
				mem_ctl.mark_wbit = 1'b1;
				mem_ctl.queue_we  = nbr_join;
				site_waddr        = nbr_addr_s1;
				queue_wdata       = nbr_addr_s1;
			end
			S_FLIP: begin
				mem_ctl.queue_re  = walk_issue;
				queue_raddr       = walk_q[QW-1:0];
				mem_ctl.spin_we   = flip_v_s1;
				mem_ctl.spin_wbit = !cluster_spin_q;
				mem_ctl.mark_we   = flip_v_s1;
				site_waddr        = queue_rdata;
			end
			default: begin
			end
		endcase
	end

	// state, pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			walk_q         <= '0;
			k_q            <= '0;
			building_q     <= 1'b0;
			cluster_spin_q <= 1'b0;
			total_q        <= MAG_INIT;
			nbr_v_s1       <= 1'b0;
			flip_v_s1      <= 1'b0;
			status_q       <= STAT_ACCEPTED;
			out_valid_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			nbr_v_s1  <= nbr_issue;
			flip_v_s1 <= walk_issue;
			// result valid: set when the result register loads, cleared on its transfer
			if (state_q == S_RESULT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (items.valid) begin
						unique case (cmd_t'(items.cmd))
							CMD_WRITE_SPIN, CMD_START: begin
								status_q <= building_q ? STAT_REJECTED : STAT_ACCEPTED;
							end
							CMD_GROW: begin
								status_q <= grow_ok ? STAT_ACCEPTED : STAT_REJECTED;
							end
							default: begin
								status_q <= building_q ? STAT_ACCEPTED : STAT_IDLE_REPORT;
							end
						endcase
					end
				end
				S_SPIN_EXEC: begin
					if (cmd_q == CMD_WRITE_SPIN) begin
						if (spin_rdata != up_q) begin
							total_q <= up_q ? total_q + SPIN_STEP : total_q - SPIN_STEP;
						end
					end else begin
						cluster_spin_q <= spin_rdata;
						head_q         <= '0;
						tail_q         <= CW'(1);
						building_q     <= 1'b1;
					end
				end
				S_HEAD_RD: begin
					head_q <= head_q + 1'b1;
				end
				S_HEAD_LATCH: begin
					k_q <= '0;
				end
				S_NBR: begin
					if (nbr_issue) k_q <= k_q + 1'b1;
					if (nbr_join) tail_q <= tail_q + 1'b1;
				end
				S_GROW_CHK: begin
					walk_q <= '0;
					if (head_q >= tail_q) status_q <= STAT_FINISHED;
				end
				S_FLIP: begin
					if (walk_issue) walk_q <= walk_q + 1'b1;
					if (flip_v_s1) begin
						total_q <= cluster_spin_q ? total_q - SPIN_STEP : total_q + SPIN_STEP;
					end
					if (!walk_issue && !flip_v_s1) building_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// item payload, neighbour stage and result payload
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_q     <= cmd_t'(items.cmd);
			row_q     <= wrap_coord(items.row);
			col_q     <= wrap_coord(items.col);
			up_q      <= items.spin_up;
			rand_q[0] <= items.rand_row_next;
			rand_q[1] <= items.rand_row_prev;
			rand_q[2] <= items.rand_col_next;
			rand_q[3] <= items.rand_col_prev;
		end
		if (state_q == S_HEAD_LATCH) begin
			cur_row_q <= queue_rdata[AW-1:RW];
			cur_col_q <= queue_rdata[RW-1:0];
		end
		if (nbr_issue) begin
			nbr_addr_s1 <= nbr_addr;
			nbr_rand_s1 <= rand_q[k_q[1:0]];
		end
		if (state_q == S_RESULT && slot_free) begin
			out_status_q  <= status_q;
			out_size_q    <= COUNT_W'(tail_q);
			out_pending_q <= COUNT_W'(tail_q - head_q);
			out_mag_q     <= MAG_W'(total_q);
		end
	end

	assign results.valid         = out_valid_q;
	assign results.status        = out_status_q;
	assign results.cluster_size  = out_size_q;
	assign results.pending_sites = out_pending_q;
	assign results.magnetization = out_mag_q;

endmodule

// ===== hw/rtl/wcsu_checker.sv =====
// wcsu_checker: port-level assertions on the wolff cluster core, attached by
// the bind at the end of this file. Depends on wcsu_pkg.
module wcsu_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [wcsu_pkg::STATUS_W-1:0]  status,
	input logic [wcsu_pkg::COUNT_W-1:0]   cluster_size,
	input logic [wcsu_pkg::COUNT_W-1:0]   pending_sites,
	input logic signed [wcsu_pkg::MAG_W-1:0] magnetization
);
	import wcsu_pkg::*;

	// no item is taken while reset holds the sequencer in its clearing state
	a_no_accept_in_reset: assert property (@(posedge clk)
		!arst_n |-> !in_ready)
		else $error("item port ready during reset");

	// one item at a time: the port drops ready right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item port still ready after a transfer");

	// a stalled result holds its payload
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(cluster_size) && $stable(pending_sites) && $stable(magnetization))
		else $error("stalled result changed");

	// a finished cluster or an idle report leaves no pending sites
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_FINISHED || status == STAT_IDLE_REPORT) |->
		pending_sites == '0)
		else $error("pending sites left while idle");

endmodule

bind wolff_cluster_spin_update_core wcsu_checker u_wcsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (items.valid),
	.in_ready      (items.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.status        (results.status),
	.cluster_size  (results.cluster_size),
	.pending_sites (results.pending_sites),
	.magnetization (results.magnetization)
);
